// ===== rtl/iecho_pkg.sv =====
// package with types and constants of the icmp echo reply filter
`timescale 1ns / 1ps
`default_nettype none

package iecho_pkg;

	localparam int MAX_PACKET_BYTES_DEF = 65535;

	localparam int BYTE_W  = 8;
	localparam int HDR_W   = 6;
	localparam int FIELD_W = 16;

	localparam int ICMP_MIN_BYTES = 8;
	localparam int TTL_OFFSET     = 8;

	localparam logic [BYTE_W-1:0] ECHO_REPLY_TYPE = 8'd0;

	// offsets inside the icmp message
	localparam int ICMP_TYPE_OFF = 0;
	localparam int ID_HI_OFF     = 4;
	localparam int ID_LO_OFF     = 5;
	localparam int SEQ_HI_OFF    = 6;
	localparam int SEQ_LO_OFF    = 7;

	typedef enum logic [1:0] {
		VERDICT_ACCEPT   = 2'd0,
		VERDICT_SHORT    = 2'd1,
		VERDICT_MISMATCH = 2'd2
	} verdict_t;

	typedef struct packed {
		verdict_t             verdict;
		logic [FIELD_W-1:0]   icmp_length;
		logic [FIELD_W-1:0]   sequence_number;
		logic [BYTE_W-1:0]    time_to_live;
	} iecho_result_t;

endpackage

`default_nettype wire

// ===== rtl/icmp_echo_reply_filter.sv =====
// top level of the icmp echo reply filter
// Takes an IPv4 packet one byte per word on the in channel (packet_byte, with
// last_byte on the final byte) and gives one verdict word per packet on the
// out channel: accepted echo reply, too short, or not a matching reply, with
// icmp length, sequence number and ttl.
// The cfg channel writes expected_identifier; cfg_ready is always high, and
// a write is meant to happen only while no packet is in flight.
// Each input word goes into an input register; the field capture logic then
// updates the packet state from it and, on the last byte, loads the
// result register, which drives out_valid. One byte is taken every cycle,
// set by the single input register stage and the single result register,
// except while a last byte waits for the result register.
// When the receiver stalls, a waiting verdict holds in the result register;
// non-final bytes keep flowing, and only a last byte waits in the input
// register until the result register frees.
// Reset clears the packet state, the identifier register and both valid
// flags.
`timescale 1ns / 1ps
`default_nettype none

module icmp_echo_reply_filter
	import iecho_pkg::*;
#(
	parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	output      logic                cfg_ready,
	input  wire logic [FIELD_W-1:0]  expected_identifier,
	input  wire logic                in_valid,
	output      logic                in_ready,
	input  wire logic [BYTE_W-1:0]   packet_byte,
	input  wire logic                last_byte,
	output      logic                out_valid,
	input  wire logic                out_ready,
	output      logic [1:0]          verdict,
	output      logic [FIELD_W-1:0]  icmp_length,
	output      logic [FIELD_W-1:0]  sequence_number,
	output      logic [BYTE_W-1:0]   time_to_live
);

	logic [FIELD_W-1:0] expected_id_q;
	logic               valid_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic               last_s1;
	logic               advance;
	iecho_result_t      result;
	iecho_result_t      result_q;
	logic               out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_id_q <= '0;
		end else if (cfg_valid) begin
			expected_id_q <= expected_identifier;
		end
	end

	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= packet_byte;
			last_s1 <= last_byte;
		end
	end

	iecho_fields #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_fields (
		.clk                (clk),
		.arst_n             (arst_n),
		.step               (advance),
		.packet_byte        (byte_s1),
		.last_byte          (last_s1),
		.expected_identifier(expected_id_q),
		.result             (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			result_q <= result;
		end
	end

	assign out_valid       = out_valid_q;
	assign verdict         = result_q.verdict;
	assign icmp_length     = result_q.icmp_length;
	assign sequence_number = result_q.sequence_number;
	assign time_to_live    = result_q.time_to_live;

	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.verdict == VERDICT_SHORT |->
			icmp_length == '0 && sequence_number == '0 && time_to_live == '0)
		else $error("short verdict with nonzero fields");

	a_len_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.verdict != VERDICT_SHORT |->
			icmp_length >= FIELD_W'(ICMP_MIN_BYTES))
		else $error("icmp length below minimum without short verdict");

	a_body_flows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !last_s1 |-> in_ready)
		else $error("non-final byte blocked the input");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> out_valid_q)
		else $error("last byte left no verdict");

endmodule

`default_nettype wire

// ===== rtl/iecho_fields.sv =====
// per-packet field capture and verdict logic of the icmp echo reply filter
`timescale 1ns / 1ps
`default_nettype none

module iecho_fields
	import iecho_pkg::*;
#(
	parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire logic [BYTE_W-1:0]   packet_byte,
	input  wire logic                last_byte,
	input  wire logic [FIELD_W-1:0]  expected_identifier,
	output iecho_result_t            result
);

	localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);

	logic [POS_W-1:0]   pos_q, pos_new;
	logic [HDR_W-1:0]   hdr_q, hdr_new;
	logic [BYTE_W-1:0]  type_q, type_new;
	logic [FIELD_W-1:0] id_q, id_new;
	logic [FIELD_W-1:0] seq_q, seq_new;
	logic [BYTE_W-1:0]  ttl_q, ttl_new;

	logic               active;
	logic [POS_W-1:0]   rel;
	logic [POS_W:0]     diff;
	logic               too_short;
	logic               match;

	always_comb begin
		active   = (pos_q != POS_W'(MAX_PACKET_BYTES));
		hdr_new  = hdr_q;
		ttl_new  = ttl_q;
		type_new = type_q;
		id_new   = id_q;
		seq_new  = seq_q;
		pos_new  = pos_q;
		rel      = '0;
		if (active) begin
			if (pos_q == '0) begin
				hdr_new = {packet_byte[3:0], 2'b00};
			end
			if (pos_q == POS_W'(TTL_OFFSET)) begin
				ttl_new = packet_byte;
			end
			rel = pos_q - POS_W'(hdr_new);
			if (pos_q >= POS_W'(hdr_new)) begin
				case (rel)
					POS_W'(ICMP_TYPE_OFF): type_new = packet_byte;
					POS_W'(ID_HI_OFF):     id_new = {packet_byte, id_q[7:0]};
					POS_W'(ID_LO_OFF):     id_new = {id_q[15:8], packet_byte};
					POS_W'(SEQ_HI_OFF):    seq_new = {packet_byte, seq_q[7:0]};
					POS_W'(SEQ_LO_OFF):    seq_new = {seq_q[15:8], packet_byte};
					default: ;
				endcase
			end
			pos_new = pos_q + POS_W'(1);
		end

		diff      = {1'b0, pos_new} - (POS_W + 1)'(hdr_new);
		too_short = diff[POS_W] || (diff[POS_W-1:0] < POS_W'(ICMP_MIN_BYTES));
		match     = (type_new == ECHO_REPLY_TYPE) && (id_new == expected_identifier);

		if (too_short) begin
			result.verdict         = VERDICT_SHORT;
			result.icmp_length     = '0;
			result.sequence_number = '0;
			result.time_to_live    = '0;
		end else begin
			result.verdict         = match ? VERDICT_ACCEPT : VERDICT_MISMATCH;
			result.icmp_length     = FIELD_W'(diff[POS_W-1:0]);
			result.sequence_number = seq_new;
			result.time_to_live    = ttl_new;
		end
	end

	// state returns to zero after the last byte of a packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			hdr_q  <= '0;
			type_q <= '0;
			id_q   <= '0;
			seq_q  <= '0;
			ttl_q  <= '0;
		end else if (step) begin
			if (last_byte) begin
				pos_q  <= '0;
				hdr_q  <= '0;
				type_q <= '0;
				id_q   <= '0;
				seq_q  <= '0;
				ttl_q  <= '0;
			end else begin
				pos_q  <= pos_new;
				hdr_q  <= hdr_new;
				type_q <= type_new;
				id_q   <= id_new;
				seq_q  <= seq_new;
				ttl_q  <= ttl_new;
			end
		end
	end

endmodule

`default_nettype wire

// ===== verif/icmp_echo_reply_filter_test.sv =====
// testbench of the icmp echo reply filter: directed and random packets, every verdict word checked
`timescale 1ns / 1ps

module icmp_echo_reply_filter_test;
	import iecho_pkg::*;

	localparam int PKT_LIMIT   = MAX_PACKET_BYTES_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_BYTES = 80;
	localparam int PHASE_PKTS  = 4;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic          typed;
		iecho_result_t res;
	} fixed_t;

	typedef struct {
		logic          do_cfg;
		logic [15:0]   cfg_val;
		int            len;
		logic [7:0]    b0;
		logic [7:0]    ttl;
		logic [7:0]    itype;
		logic [15:0]   ident;
		logic [15:0]   seq;
		logic          typed;
		iecho_result_t res;
	} pkt_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] expected_identifier = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  packet_byte = '0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  verdict;
	logic [15:0] icmp_length;
	logic [15:0] sequence_number;
	logic [7:0]  time_to_live;

	icmp_echo_reply_filter #(
		.MAX_PACKET_BYTES(PKT_LIMIT)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.expected_identifier(expected_identifier),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.packet_byte(packet_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.verdict(verdict),
		.icmp_length(icmp_length),
		.sequence_number(sequence_number),
		.time_to_live(time_to_live)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [15:0] ident_reg = '0;
	int          byte_pos = 0;
	logic [5:0]  hdr_len = '0;
	logic [7:0]  type_cap = '0;
	logic [15:0] id_cap = '0;
	logic [15:0] seq_cap = '0;
	logic [7:0]  ttl_cap = '0;

	iecho_result_t verdict_q[$];
	fixed_t        fixed_q[$];
	pkt_row_t      rows[$];
	logic [7:0]    pkt_bytes[];
	iecho_result_t pred;
	iecho_result_t want;
	fixed_t        fx;

	int fail_count = 0;
	int cycle_count = 0;
	int words_seen = 0;
	int pkts_sent = 0;
	int bytes_sent = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;
	logic [15:0] cur_ident = '0;

	function automatic logic parse_byte(input logic [7:0] b, input logic last,
			output iecho_result_t r);
		int rel;
		r = '0;
		if (byte_pos < PKT_LIMIT) begin
			if (byte_pos == 0)
				hdr_len = {b[3:0], 2'b00};
			if (byte_pos == TTL_OFFSET)
				ttl_cap = b;
			if (byte_pos >= hdr_len) begin
				rel = byte_pos - hdr_len;
				case (rel)
					ICMP_TYPE_OFF: type_cap = b;
					ID_HI_OFF:     id_cap[15:8] = b;
					ID_LO_OFF:     id_cap[7:0] = b;
					SEQ_HI_OFF:    seq_cap[15:8] = b;
					SEQ_LO_OFF:    seq_cap[7:0] = b;
					default: ;
				endcase
			end
			byte_pos = byte_pos + 1;
		end
		if (!last)
			return 1'b0;
		if (byte_pos < hdr_len || byte_pos - hdr_len < ICMP_MIN_BYTES) begin
			r.verdict = VERDICT_SHORT;
		end else begin
			if (type_cap == ECHO_REPLY_TYPE && id_cap == ident_reg)
				r.verdict = VERDICT_ACCEPT;
			else
				r.verdict = VERDICT_MISMATCH;
			r.icmp_length = 16'(byte_pos - hdr_len);
			r.sequence_number = seq_cap;
			r.time_to_live = ttl_cap;
		end
		byte_pos = 0;
		hdr_len = '0;
		type_cap = '0;
		id_cap = '0;
		seq_cap = '0;
		ttl_cap = '0;
		return 1'b1;
	endfunction

	// accepted input words and register writes feed the predictor
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				ident_reg = expected_identifier;
			if (in_valid && in_ready) begin
				if (parse_byte(packet_byte, last_byte, pred)) begin
					fx = '0;
					if (fixed_q.size() != 0)
						fx = fixed_q.pop_front();
					verdict_q.push_back(fx.typed ? fx.res : pred);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			words_seen++;
			if (verdict_q.size() == 0) begin
				$error("unexpected word: verdict %0d length %0d", verdict, icmp_length);
				fail_count++;
			end else begin
				want = verdict_q.pop_front();
				if (verdict !== want.verdict) begin
					$error("verdict: expected %0d, got %0d", want.verdict, verdict);
					fail_count++;
				end
				if (icmp_length !== want.icmp_length) begin
					$error("icmp_length: expected %0d, got %0d", want.icmp_length,
						icmp_length);
					fail_count++;
				end
				if (sequence_number !== want.sequence_number) begin
					$error("sequence_number: expected %h, got %h", want.sequence_number,
						sequence_number);
					fail_count++;
				end
				if (time_to_live !== want.time_to_live) begin
					$error("time_to_live: expected %h, got %h", want.time_to_live,
						time_to_live);
					fail_count++;
				end
			end
		end
	end

	// receiver: random stalls, long hold-off on request
	always @(posedge clk) begin
		if (hold_asks != hold_seen) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("icmp_echo_reply_filter_test: done, errors");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		packet_byte <= b;
		last_byte <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	function automatic void put_byte(input int at, input logic [7:0] v);
		if (at < pkt_bytes.size())
			pkt_bytes[at] = v;
	endfunction

	task automatic drive_packet(input int len, input logic [7:0] b0, ttl, itype,
			input logic [15:0] ident, seq, input logic typed, input iecho_result_t res);
		int hdr;
		hdr = b0[3:0] * 4;
		pkt_bytes = new[len];
		foreach (pkt_bytes[i])
			pkt_bytes[i] = 8'($urandom);
		put_byte(TTL_OFFSET, ttl);
		put_byte(hdr + ICMP_TYPE_OFF, itype);
		put_byte(hdr + ID_HI_OFF, ident[15:8]);
		put_byte(hdr + ID_LO_OFF, ident[7:0]);
		put_byte(hdr + SEQ_HI_OFF, seq[15:8]);
		put_byte(hdr + SEQ_LO_OFF, seq[7:0]);
		pkt_bytes[0] = b0;
		fixed_q.push_back({typed, res});
		for (int i = 0; i < len; i++)
			send_byte(pkt_bytes[i], i == len - 1);
		pkts_sent++;
		bytes_sent += len;
	endtask

	task automatic send_random_packet();
		int kind;
		int len;
		logic [3:0] nib;
		logic [7:0] b0;
		logic [7:0] itype;
		logic [15:0] ident;
		logic [31:0] r;
		r = $urandom;
		kind = $urandom_range(99);
		case ($urandom_range(3))
			0, 1: nib = 4'd5;
			2: nib = 4'd0;
			default: nib = r[3:0];
		endcase
		b0 = {4'd4, nib};
		if (nib == 4'd0)
			b0 = r[8] ? 8'h00 : {r[7:4], nib};
		itype = ($urandom_range(99) < 80) ? ECHO_REPLY_TYPE : r[23:16];
		case ($urandom_range(3))
			0: ident = 16'($urandom);
			1: ident = cur_ident ^ (16'h1 << $urandom_range(15));
			default: ident = cur_ident;
		endcase
		if (kind < 65) begin
			len = nib * 4 + ICMP_MIN_BYTES + $urandom_range(10);
		end else if (kind < 85) begin
			len = $urandom_range(nib * 4 + ICMP_MIN_BYTES - 1, 1);
		end else begin
			b0 = r[31:24];
			itype = r[23:16];
			ident = 16'($urandom);
			len = $urandom_range(40, 1);
		end
		drive_packet(len, b0, r[15:8], itype, ident, 16'($urandom), 1'b0, '0);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (words_seen < pkts_sent)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_ident(input logic [15:0] v);
		cfg_valid <= 1'b1;
		expected_identifier <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cur_ident = v;
	endtask

	task automatic add_row(input logic do_cfg, input logic [15:0] cfg_val, input int len,
			input logic [7:0] b0, ttl, itype, input logic [15:0] ident, seq,
			input logic typed, input iecho_result_t res);
		pkt_row_t row;
		row.do_cfg = do_cfg;
		row.cfg_val = cfg_val;
		row.len = len;
		row.b0 = b0;
		row.ttl = ttl;
		row.itype = itype;
		row.ident = ident;
		row.seq = seq;
		row.typed = typed;
		row.res = res;
		rows.push_back(row);
	endtask

	initial begin
		int start_bytes;
		int start_pkts;
		int send_pcts[4];
		int stall_pcts[4];
		logic [15:0] phase_ident[4];
		send_pcts = '{0, 77, 0, 26};
		stall_pcts = '{0, 0, 77, 26};
		phase_ident = '{16'h0000, 16'h0000, 16'hFFFF, 16'h0000};
		phase_ident[0] = 16'($urandom);
		phase_ident[3] = 16'($urandom);

		// identifier still at its reset value for the first rows
		add_row(0, 0, 8, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h1234, 1,
			'{VERDICT_ACCEPT, 16'd8, 16'h1234, 8'h00});
		add_row(0, 0, 1, 8'hFF, 8'h00, 8'h00, 16'h0000, 16'h0000, 1,
			'{VERDICT_SHORT, 16'd0, 16'h0000, 8'h00});
		add_row(0, 0, 27, 8'h45, 8'h11, 8'h00, 16'h0000, 16'h4321, 1,
			'{VERDICT_SHORT, 16'd0, 16'h0000, 8'h00});
		add_row(0, 0, 28, 8'h45, 8'hFF, 8'h00, 16'h0000, 16'hFFFF, 1,
			'{VERDICT_ACCEPT, 16'd8, 16'hFFFF, 8'hFF});
		add_row(0, 0, 28, 8'h45, 8'h01, 8'h08, 16'h0000, 16'h0001, 1,
			'{VERDICT_MISMATCH, 16'd8, 16'h0001, 8'h01});
		add_row(0, 0, 68, 8'h4F, 8'h40, 8'h00, 16'h0000, 16'h0000, 1,
			'{VERDICT_ACCEPT, 16'd8, 16'h0000, 8'h40});
		add_row(0, 0, 67, 8'h4F, 8'h40, 8'h00, 16'h0000, 16'h0000, 1,
			'{VERDICT_SHORT, 16'd0, 16'h0000, 8'h00});
		add_row(1, 16'hFFFF, 30, 8'h45, 8'h80, 8'h00, 16'hFFFF, 16'h8000, 1,
			'{VERDICT_ACCEPT, 16'd10, 16'h8000, 8'h80});
		add_row(0, 0, 28, 8'h45, 8'h7F, 8'h00, 16'hFFFE, 16'h00FF, 1,
			'{VERDICT_MISMATCH, 16'd8, 16'h00FF, 8'h7F});
		add_row(0, 0, 28, 8'h45, 8'h00, 8'hFF, 16'hFFFF, 16'hAAAA, 1,
			'{VERDICT_MISMATCH, 16'd8, 16'hAAAA, 8'h00});
		// ttl shares a byte with icmp fields here
		add_row(0, 0, 12, 8'h41, 8'h33, 8'h00, 16'hFFFF, 16'h0102, 0, '0);
		add_row(0, 0, 16, 8'h42, 8'h00, 8'h00, 16'hFFFF, 16'h0304, 0, '0);
		// zero header: byte 0 is also the icmp type
		add_row(0, 0, 9, 8'h10, 8'h5A, 8'h10, 16'hFFFF, 16'h5555, 1,
			'{VERDICT_MISMATCH, 16'd9, 16'h5555, 8'h5A});
		add_row(1, 16'h0001, 8, 8'h00, 8'h00, 8'h00, 16'h0001, 16'h0000, 1,
			'{VERDICT_ACCEPT, 16'd8, 16'h0000, 8'h00});
		add_row(0, 0, 7, 8'h00, 8'h00, 8'h00, 16'h0001, 16'h0000, 1,
			'{VERDICT_SHORT, 16'd0, 16'h0000, 8'h00});
		add_row(0, 0, 8, 8'h0F, 8'h00, 8'h00, 16'h0001, 16'h0000, 1,
			'{VERDICT_SHORT, 16'd0, 16'h0000, 8'h00});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].do_cfg) begin
				drain();
				write_ident(rows[i].cfg_val);
			end
			drive_packet(rows[i].len, rows[i].b0, rows[i].ttl, rows[i].itype, rows[i].ident,
				rows[i].seq, rows[i].typed, rows[i].res);
		end

		for (int ph = 0; ph < 4; ph++) begin
			drain();
			write_ident(phase_ident[ph]);
			idle_pct = send_pcts[ph];
			stall_pct = stall_pcts[ph];
			start_bytes = bytes_sent;
			start_pkts = pkts_sent;
			while (bytes_sent - start_bytes < PHASE_BYTES || pkts_sent - start_pkts < PHASE_PKTS)
			begin
				if (ph == 1 && pkts_sent - start_pkts == 2) begin
					// receiver holds off while minimum-length packets pile up
					hold_asks++;
					repeat (10)
						drive_packet(8, 8'h00, 8'h00, 8'h00, cur_ident, 16'($urandom),
							1'b0, '0);
					drain();
				end
				send_random_packet();
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (verdict_q.size() != 0) begin
			$error("%0d expected words never came", verdict_q.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("icmp_echo_reply_filter_test: done, clean");
		else
			$display("icmp_echo_reply_filter_test: done, errors");
		$finish;
	end

endmodule
